/* hw/rtl/tmk_pkg.sv */
// ----------------------------------------------------------------------------
// tmk_pkg: shared types and constants for the trajectory key point marker
// This package holds the payload structs of both channels, the direction codes
// and the push control that the tracker hands to the result queue.
// ----------------------------------------------------------------------------
package tmk_pkg;

  // Direction codes kept for each axis.
  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_RISING  = 2'd1;
  localparam logic [1:0] DIR_FALLING = 2'd2;

  // One trajectory point as it arrives.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [31:0] point_time;
    logic               end_of_track;
  } point_t;

  // One emitted point with its flags.
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic        [31:0] out_time;
    logic               is_key;
    logic               track_done;
  } result_t;

  // Which result slots the tracker fills in one cycle.
  typedef struct packed {
    logic push_first;
    logic push_second;
  } push_ctl_t;

endpackage

/* hw/rtl/tmk_track.sv */
// ----------------------------------------------------------------------------
// tmk_track: held point and direction tracking
// Compares each accepted point against the held point, updates the per-axis
// directions and produces up to two results for the result queue.
// ----------------------------------------------------------------------------
module tmk_track import tmk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  point_t    point_i,
  output push_ctl_t push_o,
  output result_t   first_o,
  output result_t   second_o
);

  logic signed [31:0] held_x_q, held_x_d;
  logic signed [31:0] held_y_q, held_y_d;
  logic        [31:0] held_time_q, held_time_d;
  logic               held_is_first_q, held_is_first_d;
  logic               have_held_q, have_held_d;
  logic        [1:0]  dir_x_q, dir_x_d;
  logic        [1:0]  dir_y_q, dir_y_d;

  logic               rev_x;
  logic               rev_y;
  logic               rev;
  logic        [1:0]  base_x;
  logic        [1:0]  base_y;

  // Reversal of a known direction on either axis.
  always_comb begin
    rev_x = 1'b0;
    rev_y = 1'b0;
    case (dir_x_q)
      DIR_RISING:  rev_x = point_i.point_x < held_x_q;
      DIR_FALLING: rev_x = held_x_q < point_i.point_x;
      default:     rev_x = 1'b0;
    endcase
    case (dir_y_q)
      DIR_RISING:  rev_y = point_i.point_y < held_y_q;
      DIR_FALLING: rev_y = held_y_q < point_i.point_y;
      default:     rev_y = 1'b0;
    endcase
    rev = rev_x | rev_y;
  end

  // Directions after an optional clear, then settled from the new point.
  always_comb begin
    base_x  = rev ? DIR_UNKNOWN : dir_x_q;
    base_y  = rev ? DIR_UNKNOWN : dir_y_q;
    dir_x_d = base_x;
    dir_y_d = base_y;
    if (base_x != DIR_RISING && base_x != DIR_FALLING) begin
      if (held_x_q < point_i.point_x) begin
        dir_x_d = DIR_RISING;
      end else if (point_i.point_x < held_x_q) begin
        dir_x_d = DIR_FALLING;
      end else begin
        dir_x_d = DIR_UNKNOWN;
      end
    end
    if (base_y != DIR_RISING && base_y != DIR_FALLING) begin
      if (held_y_q < point_i.point_y) begin
        dir_y_d = DIR_RISING;
      end else if (point_i.point_y < held_y_q) begin
        dir_y_d = DIR_FALLING;
      end else begin
        dir_y_d = DIR_UNKNOWN;
      end
    end
  end

  // Result items: the held point, and the current point closing a track.
  always_comb begin
    first_o.out_x      = held_x_q;
    first_o.out_y      = held_y_q;
    first_o.out_time   = held_time_q;
    first_o.is_key     = held_is_first_q | rev;
    first_o.track_done = 1'b0;
    second_o.out_x      = point_i.point_x;
    second_o.out_y      = point_i.point_y;
    second_o.out_time   = point_i.point_time;
    second_o.is_key     = 1'b1;
    second_o.track_done = 1'b1;
    if (!have_held_q) begin
      // A lone final point goes out in the first slot.
      first_o = second_o;
    end
    push_o.push_first  = fire_i & (have_held_q | point_i.end_of_track);
    push_o.push_second = fire_i & have_held_q & point_i.end_of_track;
  end

  // Next state of the held point.
  logic [1:0] next_dir_x;
  logic [1:0] next_dir_y;

  always_comb begin
    held_x_d        = held_x_q;
    held_y_d        = held_y_q;
    held_time_d     = held_time_q;
    held_is_first_d = held_is_first_q;
    have_held_d     = have_held_q;
    next_dir_x      = dir_x_q;
    next_dir_y      = dir_y_q;
    if (fire_i) begin
      if (point_i.end_of_track) begin
        // The track closes: back to the reset state.
        held_x_d        = '0;
        held_y_d        = '0;
        held_time_d     = '0;
        held_is_first_d = 1'b0;
        have_held_d     = 1'b0;
        next_dir_x      = DIR_UNKNOWN;
        next_dir_y      = DIR_UNKNOWN;
      end else begin
        held_x_d        = point_i.point_x;
        held_y_d        = point_i.point_y;
        held_time_d     = point_i.point_time;
        held_is_first_d = ~have_held_q;
        have_held_d     = 1'b1;
        next_dir_x      = have_held_q ? dir_x_d : DIR_UNKNOWN;
        next_dir_y      = have_held_q ? dir_y_d : DIR_UNKNOWN;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q        <= '0;
      held_y_q        <= '0;
      held_time_q     <= '0;
      held_is_first_q <= 1'b0;
      have_held_q     <= 1'b0;
      dir_x_q         <= DIR_UNKNOWN;
      dir_y_q         <= DIR_UNKNOWN;
    end else begin
      held_x_q        <= held_x_d;
      held_y_q        <= held_y_d;
      held_time_q     <= held_time_d;
      held_is_first_q <= held_is_first_d;
      have_held_q     <= have_held_d;
      dir_x_q         <= next_dir_x;
      dir_y_q         <= next_dir_y;
    end
  end

  // With nothing held, no direction may be known.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_held_q |-> (dir_x_q == DIR_UNKNOWN && dir_y_q == DIR_UNKNOWN))
    else $error("direction known while no point is held");

  // A final point always leaves the tracker empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && point_i.end_of_track) |=> !have_held_q)
    else $error("point still held after end of track");

  // Two results only come out when a held point meets a final point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push_second |-> have_held_q)
    else $error("second result without a held point");

endmodule

/* hw/rtl/tmk_result_fifo.sv */
// ----------------------------------------------------------------------------
// tmk_result_fifo: result queue
// Small register queue that takes up to two results a cycle and hands one
// result a cycle to the output channel while out_stall_i is low.
// ----------------------------------------------------------------------------
module tmk_result_fifo import tmk_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_ctl_t push_i,
  input  result_t   first_i,
  input  result_t   second_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output result_t   out_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] wptr_next;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  // Pointer stepping with wrap at the queue depth.
  function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(Depth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rptr_q];
  assign room_o      = cnt_q <= CntW'(Depth - 2);

  // Pointer and fill count update.
  always_comb begin
    wptr_next = step_ptr(wptr_q);
    wptr_d    = wptr_q;
    if (push_i.push_second) begin
      wptr_d = step_ptr(wptr_next);
    end else if (push_i.push_first) begin
      wptr_d = wptr_next;
    end
    rptr_d = pop ? step_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(push_i.push_first) + CntW'(push_i.push_second) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.push_first) begin
      mem_q[wptr_q] <= first_i;
    end
    if (push_i.push_second) begin
      mem_q[wptr_next] <= second_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overflow");

  // The second slot is only used together with the first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_second |-> push_i.push_first)
    else $error("second result pushed without the first");

  // Pushes only happen when two free entries were reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_first |-> room_o)
    else $error("push into a queue without room");

endmodule

/* hw/rtl/trajectory_monotone_keypoints.sv */
// ----------------------------------------------------------------------------
// trajectory_monotone_keypoints: monotone piece key point marker
// Marks the points that split a trajectory into pieces monotone in x and y.
// ----------------------------------------------------------------------------
// Usage: points enter on the in channel (in_valid_i, in_stall_o, in_data_i)
// and results leave on the out channel (out_valid_o, out_stall_i,
// out_data_o). A request is taken at a rising edge with valid high and stall
// low. Each point is emitted once, in input order, with is_key set when it
// bounds a monotone piece; the final point of a track sets track_done.
// Holding: a point is held until the next point of its track arrives; that
// request writes it into the result queue. A final point is written into the
// queue by its own request, right behind the held point.
// Throughput: one point per cycle while not stalled; a final point pushes two
// results, which the output drains one per cycle while out_stall_i is low,
// through a queue of Depth entries. in_stall_o is high while under two
// queue entries are free, so the output stall reaches the input when it fills.
// Reset: the held point and directions clear and the queue empties; the
// next point opens a new trajectory.
// ----------------------------------------------------------------------------
module trajectory_monotone_keypoints import tmk_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  point_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  push_ctl_t push;
  result_t   first_res;
  result_t   second_res;
  logic      room;
  logic      fire;

  // Input handshake.
  assign in_stall_o = ~room;
  assign fire       = in_valid_i & room;

  tmk_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .point_i  (in_data_i),
    .push_o   (push),
    .first_o  (first_res),
    .second_o (second_res)
  );

  tmk_result_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .first_i     (first_res),
    .second_i    (second_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/sv/tb_trajectory_monotone_keypoints.sv */
// ----------------------------------------------------------------------------
// tb_trajectory_monotone_keypoints: self-checking bench for the key point marker
// Streams whole trajectories into the block, predicts every emitted point with
// its key and done flags, and checks each result in order, with random gaps
// on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_trajectory_monotone_keypoints;
  import tmk_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomPoints = 1100;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  point_t  in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_data;

  point_t  pending_points[$];
  result_t expected_results[$];
  int      error_count = 0;
  int      cycle_count = 0;

  // Tracker copy: the point waiting to be emitted and the axis directions.
  logic signed [31:0] held_x = '0;
  logic signed [31:0] held_y = '0;
  logic        [31:0] held_time = '0;
  bit                 held_opens = 1'b0;
  bit                 track_open = 1'b0;
  logic        [1:0]  dir_x = DIR_UNKNOWN;
  logic        [1:0]  dir_y = DIR_UNKNOWN;

  trajectory_monotone_keypoints dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // A coordinate moving against a known direction ends the monotone piece.
  function automatic bit turns_back(logic [1:0] dir, logic signed [31:0] value,
                                    logic signed [31:0] prev);
    if (dir == DIR_RISING) return value < prev;
    if (dir == DIR_FALLING) return value > prev;
    return 1'b0;
  endfunction

  // A known direction is kept; otherwise a strict change sets a new one.
  function automatic logic [1:0] settle_dir(logic [1:0] dir, logic signed [31:0] value,
                                            logic signed [31:0] prev);
    if (dir == DIR_RISING || dir == DIR_FALLING) return dir;
    if (value > prev) return DIR_RISING;
    if (value < prev) return DIR_FALLING;
    return DIR_UNKNOWN;
  endfunction

  function automatic result_t make_result(logic signed [31:0] x, logic signed [31:0] y,
                                          logic [31:0] t, bit key, bit done);
    result_t r;
    r.out_x = x;
    r.out_y = y;
    r.out_time = t;
    r.is_key = key;
    r.track_done = done;
    return r;
  endfunction

  task automatic close_track();
    held_x = '0;
    held_y = '0;
    held_time = '0;
    held_opens = 1'b0;
    track_open = 1'b0;
    dir_x = DIR_UNKNOWN;
    dir_y = DIR_UNKNOWN;
  endtask

  // Work out the points that one accepted request releases.
  task automatic predict_point(input point_t p);
    bit flip;
    if (!track_open) begin
      if (p.end_of_track) begin
        expected_results.push_back(make_result(p.point_x, p.point_y, p.point_time,
                                               1'b1, 1'b1));
        close_track();
      end else begin
        held_x = p.point_x;
        held_y = p.point_y;
        held_time = p.point_time;
        held_opens = 1'b1;
        track_open = 1'b1;
        dir_x = DIR_UNKNOWN;
        dir_y = DIR_UNKNOWN;
      end
    end else begin
      flip = turns_back(dir_x, p.point_x, held_x) || turns_back(dir_y, p.point_y, held_y);
      if (flip) begin
        dir_x = DIR_UNKNOWN;
        dir_y = DIR_UNKNOWN;
      end
      dir_x = settle_dir(dir_x, p.point_x, held_x);
      dir_y = settle_dir(dir_y, p.point_y, held_y);
      expected_results.push_back(make_result(held_x, held_y, held_time,
                                             held_opens || flip, 1'b0));
      if (p.end_of_track) begin
        expected_results.push_back(make_result(p.point_x, p.point_y, p.point_time,
                                               1'b1, 1'b1));
        close_track();
      end else begin
        held_x = p.point_x;
        held_y = p.point_y;
        held_time = p.point_time;
        held_opens = 1'b0;
      end
    end
  endtask

  task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                           logic [31:0] t, bit last);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_time = t;
    p.end_of_track = last;
    pending_points.push_back(p);
  endtask

  // Advance one coordinate of a random walk; the sign flips now and then.
  task automatic walk_step(inout logic signed [31:0] v, inout int sgn);
    int mag;
    if ($urandom_range(0, 5) == 0) sgn = -sgn;
    if ($urandom_range(0, 19) == 0) begin
      v = $urandom;
    end else if ($urandom_range(0, 7) != 0) begin
      if ($urandom_range(0, 3) != 0) mag = $urandom_range(1, 100);
      else mag = $urandom_range(0, 1 << 20);
      v = v + sgn * mag;
    end
  endtask

  // One random trajectory, mostly smooth walks with some flat runs and jumps.
  task automatic add_track(int len);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] t;
    int sx;
    int sy;
    x = $urandom;
    y = $urandom;
    t = $urandom;
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    for (int k = 0; k < len; k++) begin
      add_point(x, y, t, k == len - 1);
      walk_step(x, sx);
      walk_step(y, sy);
      if ($urandom_range(0, 31) == 0) t = $urandom;
      else t = t + $urandom_range(1, 50);
    end
  endtask

  task automatic build_stimulus();
    int total;
    int len;
    // Single-point tracks at the coordinate and time extremes.
    add_point(32'sh8000_0000, 32'sh7fff_ffff, 32'h0000_0000, 1'b1);
    add_point(32'sh7fff_ffff, 32'sh8000_0000, 32'hffff_ffff, 1'b1);
    // Two-point track that jumps between the extremes.
    add_point(32'sh7fff_ffff, 32'sh8000_0000, 32'hffff_ffff, 1'b0);
    add_point(32'sh8000_0000, 32'sh7fff_ffff, 32'h0000_0000, 1'b1);
    // Equal coordinates never set a direction.
    add_point(7, -3, 10, 1'b0);
    add_point(7, -3, 11, 1'b0);
    add_point(7, -3, 12, 1'b1);
    // Reversals on x, one of them after a flat step.
    add_point(0, 0, 20, 1'b0);
    add_point(10, 0, 21, 1'b0);
    add_point(20, 0, 22, 1'b0);
    add_point(15, 0, 23, 1'b0);
    add_point(15, 0, 24, 1'b0);
    add_point(30, 0, 25, 1'b1);
    // Reversal on y while x keeps rising.
    add_point(1, 100, 30, 1'b0);
    add_point(2, 50, 31, 1'b0);
    add_point(3, -50, 32, 1'b0);
    add_point(4, 60, 33, 1'b1);
    // Both axes reverse on the same point.
    add_point(0, 0, 40, 1'b0);
    add_point(5, 5, 41, 1'b0);
    add_point(0, 0, 42, 1'b0);
    add_point(-5, 5, 43, 1'b1);
    // Random tracks of mixed length.
    total = 0;
    while (total < RandomPoints) begin
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = 2;
        default: len = $urandom_range(3, 40);
      endcase
      add_track(len);
      total += len;
    end
  endtask

  function automatic int draw_wait(bit bursty);
    return bursty ? $urandom_range(0, 7) : 0;
  endfunction

  // Request driver: presents queued points with random gaps between them.
  int send_wait = 0;
  bit send_bursty = 1'b1;
  always @(posedge clk) begin
    bit busy;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        predict_point(in_data);
        busy = 1'b0;
        if ($urandom_range(0, 39) == 0) send_bursty = !send_bursty;
        send_wait = draw_wait(send_bursty);
      end
      if (!busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_points.size() > 0) begin
          in_data <= pending_points.pop_front();
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // Result monitor: checks each accepted result and stalls at random after it.
  int recv_wait = 0;
  bit recv_bursty = 1'b1;
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: x %0d y %0d time %0d", out_data.out_x,
                 out_data.out_y, out_data.out_time);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, out_data.out_x);
            error_count++;
          end
          if (out_data.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, out_data.out_y);
            error_count++;
          end
          if (out_data.out_time !== want.out_time) begin
            $error("out_time: expected %0d, got %0d", want.out_time, out_data.out_time);
            error_count++;
          end
          if (out_data.is_key !== want.is_key) begin
            $error("is_key: expected %0b, got %0b", want.is_key, out_data.is_key);
            error_count++;
          end
          if (out_data.track_done !== want.track_done) begin
            $error("track_done: expected %0b, got %0b", want.track_done,
                   out_data.track_done);
            error_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_bursty = !recv_bursty;
        recv_wait = draw_wait(recv_bursty);
      end
      out_stall <= (recv_wait > 0);
      if (recv_wait > 0) recv_wait--;
    end
  end

  // Run control: reset, drain, settle, and report. The falling edge is used
  // so that every update of the rising edge has landed before the checks.
  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pending_points.size() > 0 || in_valid) @(negedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

endmodule
